/* rtl/core/dat_pkg.sv */
package dat_pkg;

  // Widths of the fixed result fields.
  localparam int unsigned TONE_W = 10;
  localparam int unsigned AVG_W  = 16;
  localparam int unsigned DATA_W = 32;

  // Tone mapping: freq = FREQ_TOP - ceil(FREQ_MUL * avg / FREQ_DIV), saturated at zero.
  localparam int unsigned FREQ_TOP = 880;
  localparam int unsigned FREQ_MUL = 11;
  localparam int unsigned FREQ_DIV = 300;

  // The rounded-up numerator at which the drop reaches FREQ_TOP.
  localparam int unsigned SAT_LIMIT = FREQ_TOP * FREQ_DIV;

  // Numerator width below the saturation limit.
  localparam int unsigned X_W = 19;

  // Reciprocal of FREQ_DIV: floor(2^RECIP_SHIFT / FREQ_DIV).
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_MUL   = (32'd1 << RECIP_SHIFT) / FREQ_DIV;
  localparam int unsigned RECIP_W     = 20;

endpackage

/* rtl/core/distance_average_to_tone.sv */
// Channel   Direction  Payload (low bit first)                 Accepted when
// s_axis    in         tdata: distance; tuser: restart         tvalid && tready
// m_axis    out        tdata: tone_freq, average, zero pad     tvalid && tready
//
// An item occupies the block from acceptance until its result is handed to the output
// register; the three-bit-per-cycle divider by the fill count sets most of that time,
// and the tone mapping adds a three-stage pipeline.
// After reset the window is empty and an item is taken at once. A result waiting on
// m_axis holds the next item only at its final hand-off into the output register.
module distance_average_to_tone import dat_pkg::*; #(
  parameter int unsigned WINDOW    = 7,
  parameter int unsigned DIST_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] distance
  input  logic              s_axis_tuser,   // [0] restart
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata    // [9:0] tone_freq, [25:10] average, rest zero
);

  localparam int unsigned AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned TOT_W = DIST_BITS + $clog2(WINDOW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_TONE,
    ST_SEND
  } state_e;

  state_e              state_q;
  logic [DIST_BITS-1:0] sample_q;
  logic [TOT_W-1:0]    total_q;
  logic [AW-1:0]       pos_q;
  logic [CNT_W-1:0]    fill_q;
  logic                m_tvalid_q;
  logic [DATA_W-1:0]   m_tdata_q;

  logic                accept;
  logic [AW-1:0]       rd_addr;
  logic [DIST_BITS-1:0] rd_data;
  logic [DIST_BITS-1:0] old_sample;
  logic [TOT_W-1:0]    total_d;
  logic [AW-1:0]       pos_d;
  logic [CNT_W-1:0]    fill_d;
  logic                div_start;
  logic                div_done;
  logic [TOT_W-1:0]    quotient;
  logic [DIST_BITS-1:0] avg;
  logic                tone_done;
  logic [TONE_W-1:0]   freq;
  logic                out_free;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_tvalid_q || m_axis_tready;

  // A restart request reads entry zero, which the fill count marks as empty.
  assign rd_addr = s_axis_tuser ? '0 : pos_q;

  // Until the ring is full the entry being replaced is still empty.
  assign old_sample = (fill_q == CNT_W'(WINDOW)) ? rd_data : '0;
  assign total_d    = total_q - TOT_W'(old_sample) + TOT_W'(sample_q);
  assign pos_d      = (pos_q == AW'(WINDOW - 1)) ? '0 : pos_q + AW'(1);
  assign fill_d     = (fill_q == CNT_W'(WINDOW)) ? fill_q : fill_q + CNT_W'(1);
  assign div_start  = (state_q == ST_UPDATE);
  assign avg        = quotient[DIST_BITS-1:0];

  dat_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_UPDATE),
    .waddr_i (pos_q),
    .wdata_i (sample_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  dat_div #(
    .NUM_W (TOT_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (total_d),
    .den_i   (fill_d),
    .done_o  (div_done),
    .quo_o   (quotient)
  );

  dat_tone #(
    .IN_W (DIST_BITS)
  ) u_tone (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_done),
    .avg_i   (avg),
    .done_o  (tone_done),
    .freq_o  (freq)
  );

  // Sequencer with the window bookkeeping and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      total_q    <= '0;
      pos_q      <= '0;
      fill_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      // The output register holds a result until the receiver takes it.
      if (state_q == ST_SEND && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser) begin
              total_q <= '0;
              pos_q   <= '0;
              fill_q  <= '0;
            end
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          total_q <= total_d;
          pos_q   <= pos_d;
          fill_q  <= fill_d;
          state_q <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state_q <= ST_TONE;
          end
        end
        ST_TONE: begin
          if (tone_done) begin
            state_q <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= DIST_BITS'(s_axis_tdata);
    end
    if (state_q == ST_SEND && out_free) begin
      m_tdata_q <= DATA_W'({AVG_W'(avg), freq});
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

/* rtl/core/dat_ram.sv */
module dat_ram import dat_pkg::*; #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 7,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/dat_div.sv */
module dat_div import dat_pkg::*; #(
  parameter int unsigned NUM_W = 19,
  parameter int unsigned DEN_W = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  // Restoring division, three quotient bits per cycle.
  localparam int unsigned STEP  = 3;
  localparam int unsigned ITER  = (NUM_W + STEP - 1) / STEP;
  localparam int unsigned PAD_W = ITER * STEP;
  localparam int unsigned CW    = $clog2(ITER + 1);

  logic             busy_q;
  logic             done_q;
  logic             den_zero_q;
  logic [CW-1:0]    cnt_q;
  logic [PAD_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;

  logic [PAD_W-1:0] num_d;
  logic [DEN_W-1:0] rem_d;

  // Three dependent shift-compare-subtract steps on a narrow remainder.
  always_comb begin
    logic [DEN_W:0] r_ext;
    num_d = num_q;
    rem_d = rem_q;
    for (int i = 0; i < STEP; i++) begin
      r_ext = {rem_d, num_d[PAD_W-1]};
      num_d = {num_d[PAD_W-2:0], 1'b0};
      if (r_ext >= {1'b0, den_q}) begin
        r_ext    = r_ext - {1'b0, den_q};
        num_d[0] = 1'b1;
      end
      rem_d = r_ext[DEN_W-1:0];
    end
  end

  // Control: load on start, count down the iterations, pulse done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ITER);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q      <= PAD_W'(num_i);
      rem_q      <= '0;
      den_q      <= den_i;
      den_zero_q <= (den_i == '0);
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  // A zero divisor yields a zero quotient.
  assign done_o = done_q;
  assign quo_o  = den_zero_q ? '0 : num_q[NUM_W-1:0];

endmodule

/* rtl/core/dat_tone.sv */
module dat_tone import dat_pkg::*; #(
  parameter int unsigned IN_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IN_W-1:0]   avg_i,
  output logic              done_o,
  output logic [TONE_W-1:0] freq_o
);

  localparam int unsigned ML_W = IN_W + 4;
  localparam int unsigned XF_W = (ML_W > X_W) ? ML_W : X_W;
  localparam int unsigned P_W  = X_W + RECIP_W;

  logic              v1_q;
  logic              v2_q;
  logic              v3_q;
  logic              sat1_q;
  logic              sat2_q;
  logic [X_W-1:0]    x1_q;
  logic [X_W-1:0]    x2_q;
  logic [P_W-1:0]    prod_q;
  logic [TONE_W-1:0] freq_q;

  logic [XF_W-1:0]   x_full;
  logic [TONE_W-1:0] q_est;
  logic [X_W-1:0]    rem;
  logic [TONE_W-1:0] drop;

  // Stage one: rounded-up numerator and the saturation test.
  assign x_full = XF_W'(avg_i) * XF_W'(FREQ_MUL) + XF_W'(FREQ_DIV - 1);

  // Stage three: reciprocal estimate is exact or one low; fix it with one compare.
  assign q_est = prod_q[RECIP_SHIFT +: TONE_W];
  assign rem   = x2_q - X_W'(q_est) * X_W'(FREQ_DIV);
  assign drop  = (rem >= X_W'(FREQ_DIV)) ? q_est + TONE_W'(1) : q_est;

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    sat1_q <= (x_full >= XF_W'(SAT_LIMIT));
    x1_q   <= x_full[X_W-1:0];
    sat2_q <= sat1_q;
    x2_q   <= x1_q;
    prod_q <= P_W'(x1_q) * P_W'(RECIP_MUL);
    if (v2_q) begin
      freq_q <= sat2_q ? '0 : TONE_W'(FREQ_TOP) - drop;
    end
  end

  assign done_o = v3_q;
  assign freq_o = freq_q;

endmodule
